// File: src/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, switched off while reset is low.
`define MIE_ASSERT(lbl_, clk_, rstn_, prop_) \
  lbl_: assert property (@(posedge clk_) disable iff (!rstn_) prop_) \
    else $error("mie: assertion failed");

// Antecedent must never hold together with the consequent being false.
`define MIE_ASSERT_IMP(lbl_, clk_, rstn_, ante_, cons_) \
  `MIE_ASSERT(lbl_, clk_, rstn_, (ante_) |-> (cons_))

`endif

// File: src/mie_pkg.sv
// Shared types and constants of the MIPS32 execute block.
// No dependencies.
package mie_pkg;

  localparam logic [31:0] PC_RESET   = 32'h0040_0000;
  localparam logic [4:0]  REG_V0     = 5'd2;
  localparam logic [4:0]  REG_RA     = 5'd31;
  localparam logic [31:0] SYS_EXIT   = 32'd10;

  // Primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6;
  localparam logic [5:0] OP_BGTZ    = 6'd7;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_ADDIU   = 6'd9;
  localparam logic [5:0] OP_SLTI    = 6'd10;
  localparam logic [5:0] OP_SLTIU   = 6'd11;
  localparam logic [5:0] OP_ANDI    = 6'd12;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_XORI    = 6'd14;
  localparam logic [5:0] OP_LUI     = 6'd15;
  localparam logic [5:0] OP_LB      = 6'd32;
  localparam logic [5:0] OP_LH      = 6'd33;
  localparam logic [5:0] OP_LW      = 6'd35;
  localparam logic [5:0] OP_LBU     = 6'd36;
  localparam logic [5:0] OP_LHU     = 6'd37;
  localparam logic [5:0] OP_SB      = 6'd40;
  localparam logic [5:0] OP_SH      = 6'd41;
  localparam logic [5:0] OP_SW      = 6'd43;

  // SPECIAL function codes
  localparam logic [5:0] FN_SLL     = 6'd0;
  localparam logic [5:0] FN_SRL     = 6'd2;
  localparam logic [5:0] FN_SRA     = 6'd3;
  localparam logic [5:0] FN_SLLV    = 6'd4;
  localparam logic [5:0] FN_SRLV    = 6'd6;
  localparam logic [5:0] FN_SRAV    = 6'd7;
  localparam logic [5:0] FN_JR      = 6'd8;
  localparam logic [5:0] FN_JALR    = 6'd9;
  localparam logic [5:0] FN_SYSCALL = 6'd12;
  localparam logic [5:0] FN_MFHI    = 6'd16;
  localparam logic [5:0] FN_MTHI    = 6'd17;
  localparam logic [5:0] FN_MFLO    = 6'd18;
  localparam logic [5:0] FN_MTLO    = 6'd19;
  localparam logic [5:0] FN_MULT    = 6'd24;
  localparam logic [5:0] FN_MULTU   = 6'd25;
  localparam logic [5:0] FN_DIV     = 6'd26;
  localparam logic [5:0] FN_DIVU    = 6'd27;
  localparam logic [5:0] FN_ADD     = 6'd32;
  localparam logic [5:0] FN_ADDU    = 6'd33;
  localparam logic [5:0] FN_SUB     = 6'd34;
  localparam logic [5:0] FN_SUBU    = 6'd35;
  localparam logic [5:0] FN_AND     = 6'd36;
  localparam logic [5:0] FN_OR      = 6'd37;
  localparam logic [5:0] FN_XOR     = 6'd38;

  // REGIMM rt codes
  localparam logic [4:0] RI_BLTZ    = 5'd0;
  localparam logic [4:0] RI_BGEZ    = 5'd1;
  localparam logic [4:0] RI_BLTZAL  = 5'd16;
  localparam logic [4:0] RI_BGEZAL  = 5'd17;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_IDX,
    ST_MEMRD,
    ST_MUL,
    ST_DIV,
    ST_WB
  } mie_state_e;

endpackage

// File: src/mie_if.sv
// Valid/ready channels of the execute block: instruction in, result out.
// No dependencies.
interface mie_instr_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr;

  modport source (output valid, output instr, input ready);
  modport sink   (input valid, input instr, output ready);
endinterface

interface mie_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        reg_we;
  logic [4:0]  reg_idx;
  logic [31:0] reg_val;
  logic        mem_we;
  logic [31:0] mem_addr;
  logic [31:0] mem_word;
  logic        halted;
  logic        illegal;

  modport source (output valid, output next_pc, output reg_we, output reg_idx,
                  output reg_val, output mem_we, output mem_addr, output mem_word,
                  output halted, output illegal, input ready);
  modport sink   (input valid, input next_pc, input reg_we, input reg_idx,
                  input reg_val, input mem_we, input mem_addr, input mem_word,
                  input halted, input illegal, output ready);
endinterface

// File: src/mips32_instruction_execute.sv
// MIPS32 single-issue integer core: one instruction item in, one result item out.
// Depends on mie_pkg and the channel interfaces in mie_if.sv.
//
// Each accepted instruction item gives one result item. Register file and data
// memory are synchronous RAMs with registered reads, so an ordinary instruction
// goes through accept with register read, execute and write back; loads and
// stores add a data memory read, preceded by index reduction when DMEM_WORDS is
// not a power of two; MULT/MULTU add one registered 33x33 multiply; DIV/DIVU
// add a divide of one quotient bit a cycle when the divisor is nonzero. One
// item is in flight at a time; the next one is taken while the previous result
// waits in the output register. After reset the register file reads zero
// through per-entry valid bits; data memory has no reset and must be written
// before it is read.
module mips32_instruction_execute #(
  parameter int DMEM_WORDS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  mie_instr_if.sink          instr_i,
  mie_result_if.source       result_o
);

  localparam int AW        = $clog2(DMEM_WORDS);
  localparam bit IDX_POW2  = (DMEM_WORDS == (1 << AW));
  localparam int FL        = $clog2(DMEM_WORDS + 1) - 1;
  localparam int IDX_STEPS = 31 - FL;
  localparam logic [31:0] DMEM_W32 = 32'(DMEM_WORDS);

  mie_pkg::mie_state_e st_q, st_d;

  // Architectural state
  logic [31:0] pc_q, hi_q, lo_q;
  logic        halt_q;
  logic [31:0] gpr_mem [32];
  logic [31:0] gpr_vld_q;
  logic [31:0] dmem [DMEM_WORDS];

  // Per-item working registers
  logic [31:0] instr_q, ra_q, rb_q, a_q, b_q, ea_q, dmem_rd_q, v0_q;
  logic        ra_vld_q, rb_vld_q;
  logic [29:0] idx_q;
  logic [4:0]  cnt_q;
  logic [63:0] prod_q;
  logic [31:0] quo_q, rem_q, dvs_q;
  logic        qneg_q, rneg_q;

  // Output register
  logic        out_valid_q;
  logic [31:0] o_npc_q, o_rval_q, o_maddr_q, o_mword_q;
  logic [4:0]  o_ridx_q;
  logic        o_rwe_q, o_mwe_q, o_halt_q, o_ill_q;

  logic in_acc, out_free, commit;

  // Field decode of the held instruction
  logic [5:0]  op, fn;
  logic [4:0]  rt, rd, sh;
  logic [31:0] simm, zimm, pc4, br_tgt;

  assign op     = instr_q[31:26];
  assign rt     = instr_q[20:16];
  assign rd     = instr_q[15:11];
  assign sh     = instr_q[10:6];
  assign fn     = instr_q[5:0];
  assign simm   = {{16{instr_q[15]}}, instr_q[15:0]};
  assign zimm   = {16'h0, instr_q[15:0]};
  assign pc4    = pc_q + 32'd4;
  assign br_tgt = pc4 + {simm[29:0], 2'b00};

  // Class of the held instruction
  logic is_ldst, is_mul, is_div, div_sgn;
  assign is_ldst = op inside {mie_pkg::OP_LB, mie_pkg::OP_LH, mie_pkg::OP_LW,
                              mie_pkg::OP_LBU, mie_pkg::OP_LHU, mie_pkg::OP_SB,
                              mie_pkg::OP_SH, mie_pkg::OP_SW};
  assign is_mul  = (op == mie_pkg::OP_SPECIAL) &&
                   (fn == mie_pkg::FN_MULT || fn == mie_pkg::FN_MULTU);
  assign is_div  = (op == mie_pkg::OP_SPECIAL) &&
                   (fn == mie_pkg::FN_DIV || fn == mie_pkg::FN_DIVU);
  assign div_sgn = (fn == mie_pkg::FN_DIV);

  // Operands straight from the register file read
  logic [31:0] a_e, b_e, ea_e, amag, bmag;
  assign a_e  = ra_vld_q ? ra_q : 32'h0;
  assign b_e  = rb_vld_q ? rb_q : 32'h0;
  assign ea_e = a_e + simm;
  assign amag = (div_sgn && a_e[31]) ? (32'h0 - a_e) : a_e;
  assign bmag = (div_sgn && b_e[31]) ? (32'h0 - b_e) : b_e;

  // Handshake
  assign in_acc          = instr_i.valid && instr_i.ready;
  assign out_free        = !out_valid_q || result_o.ready;
  assign commit          = (st_q == mie_pkg::ST_WB) && out_free;

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      mie_pkg::ST_IDLE: begin
        if (in_acc) st_d = mie_pkg::ST_EXEC;
      end
      mie_pkg::ST_EXEC: begin
        if (halt_q) st_d = mie_pkg::ST_WB;
        else if (is_ldst) st_d = IDX_POW2 ? mie_pkg::ST_MEMRD : mie_pkg::ST_IDX;
        else if (is_mul) st_d = mie_pkg::ST_MUL;
        else if (is_div && b_e != 32'h0) st_d = mie_pkg::ST_DIV;
        else st_d = mie_pkg::ST_WB;
      end
      mie_pkg::ST_IDX: begin
        if (cnt_q == 5'd0) st_d = mie_pkg::ST_MEMRD;
      end
      mie_pkg::ST_MEMRD: st_d = mie_pkg::ST_WB;
      mie_pkg::ST_MUL:   st_d = mie_pkg::ST_WB;
      mie_pkg::ST_DIV: begin
        if (cnt_q == 5'd0) st_d = mie_pkg::ST_WB;
      end
      mie_pkg::ST_WB: begin
        if (out_free) st_d = mie_pkg::ST_IDLE;
      end
      default: st_d = mie_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    instr_i.ready = (st_q == mie_pkg::ST_IDLE);
  end

  // Register file: rs and rt read at accept, one write port at commit
  logic        wb_rwe;
  logic [4:0]  wb_ridx;
  logic [31:0] wb_rval;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ra_q <= gpr_mem[instr_i.instr[25:21]];
      rb_q <= gpr_mem[instr_i.instr[20:16]];
    end
    if (commit && wb_rwe) gpr_mem[wb_ridx] <= wb_rval;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gpr_vld_q <= '0;
      ra_vld_q  <= 1'b0;
      rb_vld_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        ra_vld_q <= gpr_vld_q[instr_i.instr[25:21]];
        rb_vld_q <= gpr_vld_q[instr_i.instr[20:16]];
      end
      if (commit && wb_rwe) gpr_vld_q[wb_ridx] <= 1'b1;
    end
  end

  // Data memory: read in ST_MEMRD, written at commit
  logic        wb_mwe;
  logic [31:0] wb_mword;

  always_ff @(posedge clk_i) begin
    if (st_q == mie_pkg::ST_MEMRD) dmem_rd_q <= dmem[idx_q[AW-1:0]];
    if (commit && wb_mwe) dmem[idx_q[AW-1:0]] <= wb_mword;
  end

  // Datapath: operand capture, index reduction, multiply, divide
  logic [32:0] div_t;
  logic [31:0] idx_sub;
  assign div_t   = {rem_q, quo_q[31]};
  assign idx_sub = DMEM_W32 << cnt_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) instr_q <= instr_i.instr;
    case (st_q)
      mie_pkg::ST_EXEC: begin
        a_q    <= a_e;
        b_q    <= b_e;
        ea_q   <= ea_e;
        idx_q  <= ea_e[31:2];
        quo_q  <= amag;
        rem_q  <= 32'h0;
        dvs_q  <= bmag;
        qneg_q <= div_sgn && (a_e[31] ^ b_e[31]);
        rneg_q <= div_sgn && a_e[31];
      end
      mie_pkg::ST_IDX: begin
        if ({2'b00, idx_q} >= idx_sub) idx_q <= idx_q - idx_sub[29:0];
      end
      mie_pkg::ST_MUL: begin
        prod_q <= 64'($signed({(div_sgn | (fn == mie_pkg::FN_MULT)) & a_q[31], a_q}) *
                      $signed({(fn == mie_pkg::FN_MULT) & b_q[31], b_q}));
      end
      mie_pkg::ST_DIV: begin
        if (div_t >= {1'b0, dvs_q}) begin
          rem_q <= 32'(div_t - {1'b0, dvs_q});
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          rem_q <= div_t[31:0];
          quo_q <= {quo_q[30:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // Step counter shared by index reduction and divide
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (st_q == mie_pkg::ST_EXEC) begin
      cnt_q <= is_ldst ? 5'(IDX_STEPS - 1) : 5'd31;
    end else if (cnt_q != 5'd0) begin
      cnt_q <= cnt_q - 5'd1;
    end
  end

  // Write-back: result of the held instruction
  logic [31:0] wb_npc, wb_hi, wb_lo, ld_byte, ld_half, quo_f, rem_f;
  logic        wb_hiwe, wb_lowe, wb_ill, wb_halt, take;

  assign ld_byte = dmem_rd_q >> {ea_q[1:0], 3'b000};
  assign ld_half = ea_q[1] ? {16'h0, dmem_rd_q[31:16]} : {16'h0, dmem_rd_q[15:0]};
  assign quo_f   = qneg_q ? (32'h0 - quo_q) : quo_q;
  assign rem_f   = rneg_q ? (32'h0 - rem_q) : rem_q;

  always_comb begin
    wb_npc   = pc4;
    wb_rwe   = 1'b0;
    wb_ridx  = rt;
    wb_rval  = 32'h0;
    wb_mwe   = 1'b0;
    wb_mword = dmem_rd_q;
    wb_hiwe  = 1'b0;
    wb_lowe  = 1'b0;
    wb_hi    = a_q;
    wb_lo    = a_q;
    wb_ill   = 1'b0;
    wb_halt  = 1'b0;
    take     = 1'b0;
    case (op)
      mie_pkg::OP_SPECIAL: begin
        wb_ridx = rd;
        wb_rwe  = 1'b1;
        case (fn)
          mie_pkg::FN_ADD, mie_pkg::FN_ADDU: wb_rval = a_q + b_q;
          mie_pkg::FN_SUB, mie_pkg::FN_SUBU: wb_rval = a_q - b_q;
          mie_pkg::FN_AND:  wb_rval = a_q & b_q;
          mie_pkg::FN_OR:   wb_rval = a_q | b_q;
          mie_pkg::FN_XOR:  wb_rval = a_q ^ b_q;
          mie_pkg::FN_SLL:  wb_rval = b_q << sh;
          mie_pkg::FN_SRL:  wb_rval = b_q >> sh;
          mie_pkg::FN_SRA:  wb_rval = 32'($signed(b_q) >>> sh);
          mie_pkg::FN_SLLV: wb_rval = b_q << a_q[4:0];
          mie_pkg::FN_SRLV: wb_rval = b_q >> a_q[4:0];
          mie_pkg::FN_SRAV: wb_rval = 32'($signed(b_q) >>> a_q[4:0]);
          mie_pkg::FN_JR: begin
            wb_rwe = 1'b0;
            wb_npc = a_q;
          end
          mie_pkg::FN_JALR: begin
            wb_rval = pc4;
            wb_npc  = a_q;
          end
          mie_pkg::FN_MFHI: wb_rval = hi_q;
          mie_pkg::FN_MFLO: wb_rval = lo_q;
          mie_pkg::FN_MTHI: begin
            wb_rwe  = 1'b0;
            wb_hiwe = 1'b1;
          end
          mie_pkg::FN_MTLO: begin
            wb_rwe  = 1'b0;
            wb_lowe = 1'b1;
          end
          mie_pkg::FN_MULT, mie_pkg::FN_MULTU: begin
            wb_rwe  = 1'b0;
            wb_hiwe = 1'b1;
            wb_lowe = 1'b1;
            wb_hi   = prod_q[63:32];
            wb_lo   = prod_q[31:0];
          end
          mie_pkg::FN_DIV, mie_pkg::FN_DIVU: begin
            // divide by zero leaves HI/LO alone
            wb_rwe  = 1'b0;
            wb_hiwe = (b_q != 32'h0);
            wb_lowe = (b_q != 32'h0);
            wb_hi   = rem_f;
            wb_lo   = quo_f;
          end
          mie_pkg::FN_SYSCALL: begin
            wb_rwe = 1'b0;
            if (gpr_vld_q[mie_pkg::REG_V0] && v0_q == mie_pkg::SYS_EXIT) begin
              wb_halt = 1'b1;
              wb_npc  = pc_q;
            end
          end
          default: begin
            wb_rwe = 1'b0;
            wb_ill = 1'b1;
          end
        endcase
      end
      mie_pkg::OP_J, mie_pkg::OP_JAL: begin
        wb_npc  = {pc4[31:28], instr_q[25:0], 2'b00};
        wb_rwe  = (op == mie_pkg::OP_JAL);
        wb_ridx = mie_pkg::REG_RA;
        wb_rval = pc4;
      end
      mie_pkg::OP_REGIMM: begin
        wb_ridx = mie_pkg::REG_RA;
        wb_rval = pc4;
        case (rt)
          mie_pkg::RI_BLTZ, mie_pkg::RI_BLTZAL: take = a_q[31];
          mie_pkg::RI_BGEZ, mie_pkg::RI_BGEZAL: take = !a_q[31];
          default: wb_ill = 1'b1;
        endcase
        wb_rwe = (rt == mie_pkg::RI_BLTZAL || rt == mie_pkg::RI_BGEZAL);
        if (take) wb_npc = br_tgt;
      end
      mie_pkg::OP_BEQ:  if (a_q == b_q) wb_npc = br_tgt;
      mie_pkg::OP_BNE:  if (a_q != b_q) wb_npc = br_tgt;
      mie_pkg::OP_BLEZ: if ($signed(a_q) <= 0) wb_npc = br_tgt;
      mie_pkg::OP_BGTZ: if ($signed(a_q) > 0) wb_npc = br_tgt;
      mie_pkg::OP_ADDI, mie_pkg::OP_ADDIU: begin
        wb_rwe  = 1'b1;
        wb_rval = a_q + simm;
      end
      mie_pkg::OP_SLTI: begin
        wb_rwe  = 1'b1;
        wb_rval = {31'h0, $signed(a_q) < $signed(simm)};
      end
      mie_pkg::OP_SLTIU: begin
        wb_rwe  = 1'b1;
        wb_rval = {31'h0, a_q < simm};
      end
      mie_pkg::OP_ANDI: begin
        wb_rwe  = 1'b1;
        wb_rval = a_q & zimm;
      end
      mie_pkg::OP_ORI: begin
        wb_rwe  = 1'b1;
        wb_rval = a_q | zimm;
      end
      mie_pkg::OP_XORI: begin
        wb_rwe  = 1'b1;
        wb_rval = a_q ^ zimm;
      end
      mie_pkg::OP_LUI: begin
        wb_rwe  = 1'b1;
        wb_rval = {instr_q[15:0], 16'h0};
      end
      mie_pkg::OP_LB: begin
        wb_rwe  = 1'b1;
        wb_rval = {{24{ld_byte[7]}}, ld_byte[7:0]};
      end
      mie_pkg::OP_LH: begin
        wb_rwe  = 1'b1;
        wb_rval = {{16{ld_half[15]}}, ld_half[15:0]};
      end
      mie_pkg::OP_LW: begin
        wb_rwe  = 1'b1;
        wb_rval = dmem_rd_q;
      end
      mie_pkg::OP_LBU: begin
        wb_rwe  = 1'b1;
        wb_rval = {24'h0, ld_byte[7:0]};
      end
      mie_pkg::OP_LHU: begin
        wb_rwe  = 1'b1;
        wb_rval = ld_half;
      end
      mie_pkg::OP_SB: begin
        wb_mwe = 1'b1;
        for (int i = 0; i < 4; i++) begin
          if (ea_q[1:0] == 2'(i)) wb_mword[8*i +: 8] = b_q[7:0];
        end
      end
      mie_pkg::OP_SH: begin
        wb_mwe = 1'b1;
        if (ea_q[1]) wb_mword[31:16] = b_q[15:0];
        else wb_mword[15:0] = b_q[15:0];
      end
      mie_pkg::OP_SW: begin
        wb_mwe   = 1'b1;
        wb_mword = b_q;
      end
      default: wb_ill = 1'b1;
    endcase
    // $0 is never written
    if (wb_ridx == 5'd0) wb_rwe = 1'b0;
    // a halted core or an unknown instruction changes nothing
    if (halt_q || wb_ill) begin
      wb_npc  = pc_q;
      wb_rwe  = 1'b0;
      wb_mwe  = 1'b0;
      wb_hiwe = 1'b0;
      wb_lowe = 1'b0;
      wb_halt = 1'b0;
      wb_ill  = wb_ill && !halt_q;
    end
  end

  // $v0 shadow for the exit check, read alongside rs
  always_ff @(posedge clk_i) begin
    if (in_acc) v0_q <= gpr_mem[mie_pkg::REG_V0];
  end

  // Control state and architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= mie_pkg::ST_IDLE;
      pc_q        <= mie_pkg::PC_RESET;
      hi_q        <= '0;
      lo_q        <= '0;
      halt_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (commit) begin
        pc_q <= wb_npc;
        if (wb_hiwe) hi_q <= wb_hi;
        if (wb_lowe) lo_q <= wb_lo;
        if (wb_halt) halt_q <= 1'b1;
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result item register; unused fields read as zero
  always_ff @(posedge clk_i) begin
    if (commit) begin
      o_npc_q   <= wb_npc;
      o_rwe_q   <= wb_rwe;
      o_ridx_q  <= wb_rwe ? wb_ridx : 5'd0;
      o_rval_q  <= wb_rwe ? wb_rval : 32'h0;
      o_mwe_q   <= wb_mwe;
      o_maddr_q <= wb_mwe ? ea_q : 32'h0;
      o_mword_q <= wb_mwe ? wb_mword : 32'h0;
      o_halt_q  <= halt_q || wb_halt;
      o_ill_q   <= wb_ill;
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.next_pc  = o_npc_q;
  assign result_o.reg_we   = o_rwe_q;
  assign result_o.reg_idx  = o_ridx_q;
  assign result_o.reg_val  = o_rval_q;
  assign result_o.mem_we   = o_mwe_q;
  assign result_o.mem_addr = o_maddr_q;
  assign result_o.mem_word = o_mword_q;
  assign result_o.halted   = o_halt_q;
  assign result_o.illegal  = o_ill_q;

endmodule

// File: src/mie_checker.sv
// Port-level checks on the result channel of the execute block, and its bind.
// Depends on assert_macros.svh and the top level mips32_instruction_execute.
`include "assert_macros.svh"

module mie_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] next_pc_i,
  input logic        reg_we_i,
  input logic [4:0]  reg_idx_i,
  input logic        mem_we_i,
  input logic        halted_i,
  input logic        illegal_i
);

  // a stalled item holds its next PC
  `MIE_ASSERT_IMP(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, ##1 $stable(next_pc_i))

  // an unknown instruction writes nothing
  `MIE_ASSERT_IMP(a_ill_nowr, clk_i, rst_ni, out_valid_i && illegal_i, !reg_we_i && !mem_we_i)

  // $0 is never reported as written
  `MIE_ASSERT_IMP(a_r0, clk_i, rst_ni, out_valid_i && reg_we_i, reg_idx_i != 5'd0)

  // a halted core reports no illegal instruction and no memory write
  `MIE_ASSERT_IMP(a_halt, clk_i, rst_ni, out_valid_i && halted_i, !illegal_i && !mem_we_i)

endmodule

bind mips32_instruction_execute mie_checker u_mie_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .next_pc_i   (result_o.next_pc),
  .reg_we_i    (result_o.reg_we),
  .reg_idx_i   (result_o.reg_idx),
  .mem_we_i    (result_o.mem_we),
  .halted_i    (result_o.halted),
  .illegal_i   (result_o.illegal)
);

// File: dv/mips32_instruction_execute_tb.sv
// Self-checking testbench for mips32_instruction_execute.
// Depends on mie_pkg and the channel interfaces in mie_if.sv; predicts each
// result item with a scoreboard class that holds its own copy of the core state.
`timescale 1ns / 100ps

module mips32_instruction_execute_tb;

  localparam int DMEM_WORDS = 1024;
  localparam int N_RANDOM   = 1900;
  localparam int MAX_CYCLES = 1_000_000;
  localparam int DRAIN      = 60;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_we;
    logic [4:0]  reg_idx;
    logic [31:0] reg_val;
    logic        mem_we;
    logic [31:0] mem_addr;
    logic [31:0] mem_word;
    logic        halted;
    logic        illegal;
  } exec_result_t;

  // Architectural shadow of the core plus the queue of predicted results
  class exec_scoreboard;
    logic [31:0]  gpr [32];
    logic [31:0]  hi, lo, pc;
    logic [31:0]  dmem [DMEM_WORDS];
    bit           written [DMEM_WORDS];
    int           written_q [$];
    bit           halt;
    exec_result_t expected_q [$];
    int           errors;

    function new();
      foreach (gpr[i]) gpr[i] = '0;
      foreach (written[i]) written[i] = 1'b0;
      hi = '0; lo = '0; pc = mie_pkg::PC_RESET; halt = 1'b0; errors = 0;
    endfunction

    // Execute one accepted instruction item and queue its result
    function void note_instr(logic [31:0] w);
      exec_result_t r;
      logic [5:0]  op, fn;
      logic [4:0]  rs, rt, rd, sa, widx;
      logic [31:0] a, b, simm, zimm, pc4, npc, ea, word, wval, mword, tmp;
      logic [4:0]  bl, hl;
      logic [63:0] prod;
      longint      sa64, sb64;
      int          x, y;
      bit          we, mwe, bad, take;
      r = '0;
      if (halt) begin
        r.next_pc = pc;
        r.halted  = 1'b1;
        expected_q.push_back(r);
        return;
      end
      op = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11];
      sa = w[10:6];  fn = w[5:0];
      a = gpr[rs]; b = gpr[rt];
      simm = {{16{w[15]}}, w[15:0]};
      zimm = {16'b0, w[15:0]};
      pc4 = pc + 32'd4; npc = pc4;
      ea = a + simm;
      word = dmem[ea[11:2]];
      bl = {ea[1:0], 3'b000};
      hl = {ea[1], 4'b0000};
      we = 1'b0; mwe = 1'b0; bad = 1'b0;
      widx = '0; wval = '0; mword = '0;
      if (op == mie_pkg::OP_SPECIAL) begin
        widx = rd; we = 1'b1;
        case (fn)
          mie_pkg::FN_ADD, mie_pkg::FN_ADDU: wval = a + b;
          mie_pkg::FN_SUB, mie_pkg::FN_SUBU: wval = a - b;
          mie_pkg::FN_AND:  wval = a & b;
          mie_pkg::FN_OR:   wval = a | b;
          mie_pkg::FN_XOR:  wval = a ^ b;
          mie_pkg::FN_SLL:  wval = b << sa;
          mie_pkg::FN_SRL:  wval = b >> sa;
          mie_pkg::FN_SRA:  wval = $signed(b) >>> sa;
          mie_pkg::FN_SLLV: wval = b << a[4:0];
          mie_pkg::FN_SRLV: wval = b >> a[4:0];
          mie_pkg::FN_SRAV: wval = $signed(b) >>> a[4:0];
          mie_pkg::FN_JR:   begin we = 1'b0; npc = a; end
          mie_pkg::FN_JALR: begin wval = pc4; npc = a; end
          mie_pkg::FN_MFHI: wval = hi;
          mie_pkg::FN_MFLO: wval = lo;
          mie_pkg::FN_MTHI: begin we = 1'b0; hi = a; end
          mie_pkg::FN_MTLO: begin we = 1'b0; lo = a; end
          mie_pkg::FN_MULT: begin
            we = 1'b0;
            sa64 = longint'($signed(a)); sb64 = longint'($signed(b));
            prod = sa64 * sb64;
            hi = prod[63:32]; lo = prod[31:0];
          end
          mie_pkg::FN_MULTU: begin
            we = 1'b0;
            prod = {32'b0, a} * {32'b0, b};
            hi = prod[63:32]; lo = prod[31:0];
          end
          mie_pkg::FN_DIV: begin
            we = 1'b0;
            if (b != 0) begin
              if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
                lo = 32'h8000_0000; hi = '0;
              end else begin
                x = $signed(a); y = $signed(b);
                lo = x / y; hi = x % y;
              end
            end
          end
          mie_pkg::FN_DIVU: begin
            we = 1'b0;
            if (b != 0) begin lo = a / b; hi = a % b; end
          end
          mie_pkg::FN_SYSCALL: begin
            we = 1'b0;
            if (gpr[mie_pkg::REG_V0] == mie_pkg::SYS_EXIT) begin
              halt = 1'b1; npc = pc;
            end
          end
          default: begin bad = 1'b1; we = 1'b0; end
        endcase
      end else if (op == mie_pkg::OP_J || op == mie_pkg::OP_JAL) begin
        npc = {pc4[31:28], w[25:0], 2'b00};
        if (op == mie_pkg::OP_JAL) begin
          we = 1'b1; widx = mie_pkg::REG_RA; wval = pc4;
        end
      end else if (op == mie_pkg::OP_REGIMM) begin
        take = 1'b0;
        if (rt == mie_pkg::RI_BLTZ || rt == mie_pkg::RI_BLTZAL) take = a[31];
        else if (rt == mie_pkg::RI_BGEZ || rt == mie_pkg::RI_BGEZAL) take = !a[31];
        else bad = 1'b1;
        if (!bad) begin
          if (take) npc = pc4 + (simm << 2);
          if (rt == mie_pkg::RI_BLTZAL || rt == mie_pkg::RI_BGEZAL) begin
            we = 1'b1; widx = mie_pkg::REG_RA; wval = pc4;
          end
        end
      end else begin
        widx = rt; we = 1'b1;
        case (op)
          mie_pkg::OP_BEQ: begin
            we = 1'b0; if (a == b) npc = pc4 + (simm << 2);
          end
          mie_pkg::OP_BNE: begin
            we = 1'b0; if (a != b) npc = pc4 + (simm << 2);
          end
          mie_pkg::OP_BLEZ: begin
            we = 1'b0; if ($signed(a) <= 0) npc = pc4 + (simm << 2);
          end
          mie_pkg::OP_BGTZ: begin
            we = 1'b0; if ($signed(a) > 0) npc = pc4 + (simm << 2);
          end
          mie_pkg::OP_ADDI, mie_pkg::OP_ADDIU: wval = a + simm;
          mie_pkg::OP_SLTI:  wval = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
          mie_pkg::OP_SLTIU: wval = (a < simm) ? 32'd1 : 32'd0;
          mie_pkg::OP_ANDI: wval = a & zimm;
          mie_pkg::OP_ORI:  wval = a | zimm;
          mie_pkg::OP_XORI: wval = a ^ zimm;
          mie_pkg::OP_LUI:  wval = zimm << 16;
          mie_pkg::OP_LB: begin tmp = word >> bl; wval = {{24{tmp[7]}}, tmp[7:0]}; end
          mie_pkg::OP_LH: begin tmp = word >> hl; wval = {{16{tmp[15]}}, tmp[15:0]}; end
          mie_pkg::OP_LW:  wval = word;
          mie_pkg::OP_LBU: begin tmp = word >> bl; wval = {24'b0, tmp[7:0]}; end
          mie_pkg::OP_LHU: begin tmp = word >> hl; wval = {16'b0, tmp[15:0]}; end
          mie_pkg::OP_SB: begin
            we = 1'b0; mwe = 1'b1;
            mword = (word & ~(32'hFF << bl)) | ({24'b0, b[7:0]} << bl);
          end
          mie_pkg::OP_SH: begin
            we = 1'b0; mwe = 1'b1;
            mword = (word & ~(32'hFFFF << hl)) | ({16'b0, b[15:0]} << hl);
          end
          mie_pkg::OP_SW: begin we = 1'b0; mwe = 1'b1; mword = b; end
          default: begin bad = 1'b1; we = 1'b0; end
        endcase
      end
      if (bad) begin
        r.next_pc = pc;
        r.illegal = 1'b1;
        r.halted  = halt;
        expected_q.push_back(r);
        return;
      end
      if (we && widx != 0) begin
        gpr[widx] = wval;
        r.reg_we = 1'b1; r.reg_idx = widx; r.reg_val = wval;
      end
      if (mwe) begin
        dmem[ea[11:2]] = mword;
        if (!written[ea[11:2]]) begin
          written[ea[11:2]] = 1'b1;
          written_q.push_back(int'(ea[11:2]));
        end
        r.mem_we = 1'b1; r.mem_addr = ea; r.mem_word = mword;
      end
      pc = npc;
      r.next_pc = npc;
      r.halted  = halt;
      expected_q.push_back(r);
    endfunction

    function void field_check(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      end
    endfunction

    // Compare one accepted result item with the oldest prediction
    function void check_result(exec_result_t act);
      exec_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item, expected none, got %h", $time, act);
        return;
      end
      e = expected_q.pop_front();
      field_check("next_pc",  e.next_pc,       act.next_pc);
      field_check("reg_we",   32'(e.reg_we),   32'(act.reg_we));
      field_check("reg_idx",  32'(e.reg_idx),  32'(act.reg_idx));
      field_check("reg_val",  e.reg_val,       act.reg_val);
      field_check("mem_we",   32'(e.mem_we),   32'(act.mem_we));
      field_check("mem_addr", e.mem_addr,      act.mem_addr);
      field_check("mem_word", e.mem_word,      act.mem_word);
      field_check("halted",   32'(e.halted),   32'(act.halted));
      field_check("illegal",  32'(e.illegal),  32'(act.illegal));
    endfunction

    // True when the word would not read a data memory word never written
    function bit mem_safe(logic [31:0] w);
      logic [5:0]  op;
      logic [31:0] ea;
      op = w[31:26];
      ea = gpr[w[25:21]] + {{16{w[15]}}, w[15:0]};
      if (halt) return 1'b1;
      if (op inside {mie_pkg::OP_LB, mie_pkg::OP_LH, mie_pkg::OP_LW, mie_pkg::OP_LBU,
                     mie_pkg::OP_LHU, mie_pkg::OP_SB, mie_pkg::OP_SH})
        return written[ea[11:2]];
      return 1'b1;
    endfunction

    function bit halts(logic [31:0] w);
      return !halt && w[31:26] == mie_pkg::OP_SPECIAL && w[5:0] == mie_pkg::FN_SYSCALL &&
             gpr[mie_pkg::REG_V0] == mie_pkg::SYS_EXIT;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;
  bit   no_idle = 1'b0;
  int   stall_left = 0;

  mie_instr_if  instr_bus ();
  mie_result_if result_bus ();
  exec_scoreboard sb = new();

  mips32_instruction_execute #(.DMEM_WORDS(DMEM_WORDS)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .instr_i (instr_bus),
    .result_o(result_bus)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Run guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: check accepted items, stall at random
  initial result_bus.ready = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_bus.valid && result_bus.ready)
        sb.check_result({result_bus.next_pc, result_bus.reg_we, result_bus.reg_idx,
                         result_bus.reg_val, result_bus.mem_we, result_bus.mem_addr,
                         result_bus.mem_word, result_bus.halted, result_bus.illegal});
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        result_bus.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 99) < 25) begin
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2);
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] r_word(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                         logic [4:0] sa, logic [5:0] fn);
    return {mie_pkg::OP_SPECIAL, rs, rt, rd, sa, fn};
  endfunction

  function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [4:0] any_reg();
    return ($urandom_range(0, 9) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
  endfunction

  // One structured instruction with random content
  function automatic logic [31:0] make_instr();
    logic [5:0]  fns [] = '{mie_pkg::FN_ADD, mie_pkg::FN_ADDU, mie_pkg::FN_SUB,
                            mie_pkg::FN_SUBU, mie_pkg::FN_AND, mie_pkg::FN_OR,
                            mie_pkg::FN_XOR, mie_pkg::FN_SLL, mie_pkg::FN_SRL,
                            mie_pkg::FN_SRA, mie_pkg::FN_SLLV, mie_pkg::FN_SRLV,
                            mie_pkg::FN_SRAV, mie_pkg::FN_JR, mie_pkg::FN_JALR,
                            mie_pkg::FN_MFHI, mie_pkg::FN_MFLO, mie_pkg::FN_MTHI,
                            mie_pkg::FN_MTLO, mie_pkg::FN_MULT, mie_pkg::FN_MULTU,
                            mie_pkg::FN_DIV, mie_pkg::FN_DIVU, mie_pkg::FN_SYSCALL};
    logic [5:0]  iops [] = '{mie_pkg::OP_ADDI, mie_pkg::OP_ADDIU, mie_pkg::OP_SLTI,
                             mie_pkg::OP_SLTIU, mie_pkg::OP_ANDI, mie_pkg::OP_ORI,
                             mie_pkg::OP_XORI, mie_pkg::OP_LUI, mie_pkg::OP_BEQ,
                             mie_pkg::OP_BNE, mie_pkg::OP_BLEZ, mie_pkg::OP_BGTZ};
    logic [5:0]  mops [] = '{mie_pkg::OP_LB, mie_pkg::OP_LH, mie_pkg::OP_LW,
                             mie_pkg::OP_LBU, mie_pkg::OP_LHU, mie_pkg::OP_SB,
                             mie_pkg::OP_SH};
    logic [4:0]  rims [] = '{mie_pkg::RI_BLTZ, mie_pkg::RI_BGEZ, mie_pkg::RI_BLTZAL,
                             mie_pkg::RI_BGEZAL};
    logic [4:0]  rs;
    logic [11:0] target;
    logic [31:0] w;
    int          k;
    k = $urandom_range(0, 99);
    rs = any_reg();
    if (k < 10) begin
      w = $urandom();
    end else if (k < 38) begin
      w = r_word(rs, any_reg(), any_reg(), 5'($urandom()), fns[$urandom_range(0, 23)]);
    end else if (k < 62) begin
      w = i_word(iops[$urandom_range(0, 11)], rs, any_reg(), 16'($urandom()));
    end else if (k < 68) begin
      w = (k < 66) ? i_word(mie_pkg::OP_REGIMM, rs, rims[$urandom_range(0, 3)],
                            16'($urandom()))
                   : {($urandom_range(0, 1) ? mie_pkg::OP_JAL : mie_pkg::OP_J),
                      26'($urandom())};
    end else if (k < 80 || sb.written_q.size() == 0) begin
      w = i_word(mie_pkg::OP_SW, rs, any_reg(), 16'($urandom()));
    end else begin
      // aim the effective address at a word already written
      target = {10'(sb.written_q[$urandom_range(0, sb.written_q.size() - 1)]),
                2'($urandom())};
      w = i_word(mops[$urandom_range(0, 6)], rs, any_reg(),
                 16'($signed({1'b0, target}) - $signed({1'b0, sb.gpr[rs][11:0]})));
    end
    return w;
  endfunction

  // Offer one instruction item and wait until it is taken
  task automatic send_instr(logic [31:0] w);
    int gap;
    instr_bus.valid <= 1'b1;
    instr_bus.instr <= w;
    @(posedge clk_i);
    while (!instr_bus.ready) @(posedge clk_i);
    sb.note_instr(w);
    gap = gap_len();
    if (gap > 0) begin
      instr_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random();
    logic [31:0] w;
    w = make_instr();
    while (!sb.mem_safe(w) || sb.halts(w)) w = make_instr();
    send_instr(w);
  endtask

  task automatic wait_drained();
    instr_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    instr_bus.valid = 1'b0;
    instr_bus.instr = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, overflow, divide corners, lanes, links, $0, illegal
    send_instr(i_word(mie_pkg::OP_LUI,   5'd0, 5'd1, 16'h8000));
    send_instr(i_word(mie_pkg::OP_ADDIU, 5'd0, 5'd2, 16'hFFFF));
    send_instr(r_word(5'd1, 5'd2, 5'd3, 5'd0, mie_pkg::FN_ADD));
    send_instr(r_word(5'd1, 5'd2, 5'd0, 5'd0, mie_pkg::FN_SUB));
    send_instr(r_word(5'd1, 5'd2, 5'd0, 5'd0, mie_pkg::FN_DIV));
    send_instr(r_word(5'd0, 5'd0, 5'd4, 5'd0, mie_pkg::FN_MFLO));
    send_instr(r_word(5'd0, 5'd0, 5'd5, 5'd0, mie_pkg::FN_MFHI));
    send_instr(r_word(5'd1, 5'd0, 5'd0, 5'd0, mie_pkg::FN_DIVU));
    send_instr(r_word(5'd1, 5'd2, 5'd0, 5'd0, mie_pkg::FN_MULT));
    send_instr(r_word(5'd2, 5'd2, 5'd0, 5'd0, mie_pkg::FN_MULTU));
    send_instr(r_word(5'd0, 5'd0, 5'd6, 5'd0, mie_pkg::FN_MFHI));
    send_instr(i_word(mie_pkg::OP_SW,  5'd0, 5'd2, 16'h0000));
    send_instr(i_word(mie_pkg::OP_SB,  5'd0, 5'd0, 16'h0001));
    send_instr(i_word(mie_pkg::OP_LB,  5'd0, 5'd7, 16'h0003));
    send_instr(i_word(mie_pkg::OP_LBU, 5'd0, 5'd8, 16'h0003));
    send_instr(i_word(mie_pkg::OP_SH,  5'd0, 5'd1, 16'h0002));
    send_instr(i_word(mie_pkg::OP_LH,  5'd0, 5'd9, 16'h0003));
    send_instr(i_word(mie_pkg::OP_LHU, 5'd0, 5'd9, 16'h0002));
    send_instr(i_word(mie_pkg::OP_SLTIU, 5'd1, 5'd10, 16'hFFFF));
    send_instr(i_word(mie_pkg::OP_SLTI,  5'd1, 5'd11, 16'h7FFF));
    send_instr(r_word(5'd2, 5'd1, 5'd12, 5'd0, mie_pkg::FN_SRAV));
    send_instr(i_word(mie_pkg::OP_REGIMM, 5'd2, mie_pkg::RI_BGEZAL, 16'h0004));
    send_instr(i_word(mie_pkg::OP_ADDIU, 5'd0, 5'd0, 16'h1234));
    send_instr(r_word(5'd0, 5'd0, 5'd0, 5'd0, mie_pkg::FN_SYSCALL));
    send_instr({6'd63, 26'h3FF_FFFF});

    // Random phase, with one pause for the whole pipeline to empty
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 300 == 0) no_idle = !no_idle;
      if (i == N_RANDOM / 2) wait_drained();
      send_random();
    end

    // Halt, then confirm nothing moves afterwards
    send_instr(i_word(mie_pkg::OP_ADDIU, 5'd0, mie_pkg::REG_V0, 16'd10));
    send_instr(r_word(5'd0, 5'd0, 5'd0, 5'd0, mie_pkg::FN_SYSCALL));
    repeat (4) send_instr($urandom());

    wait_drained();
    repeat (DRAIN) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
